/* src/tapwm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the three-axis PID wheel mixer.
// No dependencies; every module of the block imports this package.
package tapwm_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DRIVE_TARGET = 3'd0,
    REG_TURN_TARGET  = 3'd1,
    REG_SIDE_TARGET  = 3'd2,
    REG_DRIVE_KP     = 3'd3,
    REG_DRIVE_KI     = 3'd4,
    REG_DRIVE_KD     = 3'd5,
    REG_TURN_KP      = 3'd6,
    REG_TURN_KD      = 3'd7
  } cfg_reg_t;

  // Fixed side-axis gains, Q8.8: 2.25 and 0.1 (rounded)
  localparam logic signed [10:0] SIDE_KP_Q8 = 11'sd576;
  localparam logic signed [5:0]  SIDE_KD_Q8 = 6'sd26;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [23:0] drive_target;
    logic        [8:0]  turn_target;
    logic signed [23:0] side_target;
    logic        [15:0] drive_kp;
    logic        [15:0] drive_ki;
    logic        [15:0] drive_kd;
    logic        [15:0] turn_kp;
    logic        [15:0] turn_kd;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    drive_target: 24'sd0,
    turn_target:  9'd0,
    side_target:  24'sd0,
    drive_kp:     16'd768,
    drive_ki:     16'd5,
    drive_kd:     16'd179,
    turn_kp:      16'd1792,
    turn_kd:      16'd51
  };

  // Errors, deltas and the updated error sum of one sample
  typedef struct packed {
    logic signed [24:0] de;
    logic signed [9:0]  te;
    logic signed [24:0] se;
    logic signed [25:0] dd;
    logic signed [10:0] td;
    logic signed [25:0] sd;
    logic signed [47:0] sum;
  } err_t;

  // Gain products, Q.8
  typedef struct packed {
    logic signed [41:0] dkp;
    logic signed [42:0] dkd;
    logic signed [63:0] dki;
    logic signed [26:0] tkp;
    logic signed [27:0] tkd;
    logic signed [35:0] skp;
    logic signed [31:0] skd;
  } prod_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] turn;
    logic signed [31:0] side;
  } pow_t;

  typedef struct packed {
    logic signed [31:0] front_right;
    logic signed [31:0] front_left;
    logic signed [31:0] back_right;
    logic signed [31:0] back_left;
  } spd_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* src/three_axis_pid_wheel_mixer.sv */
`timescale 1ns / 1ps
// Top level of the three-axis PID controller with four-wheel mixer.
// Depends on tapwm_pkg and the tapwm_*_stage modules.
//
//   channel   handshake            payload
//   in_       in_valid/in_ready    forward_position, side_position, heading
//   out_      out_valid/out_ready  three axis powers, four wheel speeds
//   cfg_      cfg_we               cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_ready is high; out_valid comes
// from the last of the four register stages (errors, multipliers, power
// sums, wheel mix). The error state updates in the first stage.
// Synchronous reset clears the stage valids, the error state and loads the
// default gains and targets. A stalled output holds its stage; each upstream
// stage keeps accepting until it is full too.
module three_axis_pid_wheel_mixer import tapwm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [23:0]     in_forward_position,
  input  logic signed [23:0]     in_side_position,
  input  logic        [8:0]      in_heading,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     out_drive_power,
  output logic signed [31:0]     out_turn_power,
  output logic signed [31:0]     out_side_power,
  output logic signed [31:0]     out_front_right_speed,
  output logic signed [31:0]     out_front_left_speed,
  output logic signed [31:0]     out_back_right_speed,
  output logic signed [31:0]     out_back_left_speed
);

  cfg_t  cfg_r, cfg_nxt;

  logic  err_valid, err_ready;
  err_t  err;
  logic  mul_valid, mul_ready;
  prod_t prod;
  logic  pow_valid, pow_ready;
  pow_t  pow;
  pow_t  out_pow;
  spd_t  out_spd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DRIVE_TARGET: cfg_nxt.drive_target = $signed(cfg_wdata[23:0]);
        REG_TURN_TARGET:  cfg_nxt.turn_target  = cfg_wdata[8:0];
        REG_SIDE_TARGET:  cfg_nxt.side_target  = $signed(cfg_wdata[23:0]);
        REG_DRIVE_KP:     cfg_nxt.drive_kp     = cfg_wdata[15:0];
        REG_DRIVE_KI:     cfg_nxt.drive_ki     = cfg_wdata[15:0];
        REG_DRIVE_KD:     cfg_nxt.drive_kd     = cfg_wdata[15:0];
        REG_TURN_KP:      cfg_nxt.turn_kp      = cfg_wdata[15:0];
        REG_TURN_KD:      cfg_nxt.turn_kd      = cfg_wdata[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tapwm_err_stage u_err (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_forward_position (in_forward_position),
    .in_side_position    (in_side_position),
    .in_heading          (in_heading),
    .out_valid           (err_valid),
    .out_ready           (err_ready),
    .out_err             (err)
  );

  tapwm_mul_stage u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_err    (err),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_prod  (prod)
  );

  tapwm_pow_stage u_pow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_prod   (prod),
    .out_valid (pow_valid),
    .out_ready (pow_ready),
    .out_pow   (pow)
  );

  tapwm_mix_stage u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pow_valid),
    .in_ready  (pow_ready),
    .in_pow    (pow),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pow   (out_pow),
    .out_spd   (out_spd)
  );

  assign out_drive_power       = out_pow.drive;
  assign out_turn_power        = out_pow.turn;
  assign out_side_power        = out_pow.side;
  assign out_front_right_speed = out_spd.front_right;
  assign out_front_left_speed  = out_spd.front_left;
  assign out_back_right_speed  = out_spd.back_right;
  assign out_back_left_speed   = out_spd.back_left;

endmodule

/* src/tapwm_err_stage.sv */
`timescale 1ns / 1ps
// First pipeline stage: axis errors, deltas and the saturating drive error sum.
// Holds the controller state. Depends on tapwm_pkg.
module tapwm_err_stage import tapwm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_forward_position,
  input  logic signed [23:0] in_side_position,
  input  logic        [8:0]  in_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output err_t               out_err
);

  logic               valid_r, valid_nxt;
  err_t               err_r, err_nxt;
  logic signed [24:0] drive_last_r, drive_last_nxt;
  logic signed [9:0]  turn_last_r, turn_last_nxt;
  logic signed [24:0] side_last_r, side_last_nxt;
  logic signed [47:0] sum_r, sum_nxt;

  logic               acc;
  logic signed [24:0] de, se;
  logic signed [9:0]  te;
  logic signed [48:0] sum_wide;
  logic signed [47:0] sum_sat;

  assign in_ready  = !valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_err   = err_r;

  assign de = 25'(cfg.drive_target) - 25'(in_forward_position);
  assign se = 25'(cfg.side_target) - 25'(in_side_position);
  assign te = $signed({1'b0, cfg.turn_target}) - $signed({1'b0, in_heading});

  assign sum_wide = 49'(sum_r) + 49'(de);

  always_comb begin
    if (sum_wide[48] != sum_wide[47]) begin
      sum_sat = sum_wide[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      sum_sat = sum_wide[47:0];
    end
  end

  always_comb begin
    valid_nxt      = in_ready ? in_valid : valid_r;
    err_nxt        = err_r;
    drive_last_nxt = drive_last_r;
    turn_last_nxt  = turn_last_r;
    side_last_nxt  = side_last_r;
    sum_nxt        = sum_r;
    if (acc) begin
      err_nxt.de     = de;
      err_nxt.te     = te;
      err_nxt.se     = se;
      err_nxt.dd     = 26'(de) - 26'(drive_last_r);
      err_nxt.td     = 11'(te) - 11'(turn_last_r);
      err_nxt.sd     = 26'(se) - 26'(side_last_r);
      err_nxt.sum    = sum_sat;
      drive_last_nxt = de;
      turn_last_nxt  = te;
      side_last_nxt  = se;
      sum_nxt        = sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      drive_last_r <= '0;
      turn_last_r  <= '0;
      side_last_r  <= '0;
      sum_r        <= '0;
    end else begin
      valid_r      <= valid_nxt;
      drive_last_r <= drive_last_nxt;
      turn_last_r  <= turn_last_nxt;
      side_last_r  <= side_last_nxt;
      sum_r        <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> drive_last_r == err_r.de)
    else $error("drive last error does not track the staged error");

  assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(sum_r) && $stable(turn_last_r))
    else $error("controller state changed without a transaction");

  assert property (@(posedge clk) disable iff (!rst_n)
    acc && !sum_r[47] && !de[24] |=> !sum_r[47])
    else $error("error sum wrapped negative");

  assert property (@(posedge clk) disable iff (!rst_n)
    acc && sum_r[47] && de[24] |=> sum_r[47])
    else $error("error sum wrapped positive");
`endif

endmodule

/* src/tapwm_mul_stage.sv */
`timescale 1ns / 1ps
// Second pipeline stage: one multiplier per gain term, products registered.
// Depends on tapwm_pkg.
module tapwm_mul_stage import tapwm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  err_t  in_err,
  output logic  out_valid,
  input  logic  out_ready,
  output prod_t out_prod
);

  logic  valid_r, valid_nxt;
  prod_t prod_r, prod_nxt;
  prod_t prod;
  logic  acc;

  assign in_ready  = !valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_prod  = prod_r;

  // Gains are unsigned; a zero top bit makes them signed operands
  assign prod.dkp = in_err.de * $signed({1'b0, cfg.drive_kp});
  assign prod.dkd = in_err.dd * $signed({1'b0, cfg.drive_kd});
  assign prod.dki = in_err.sum * $signed({1'b0, cfg.drive_ki});
  assign prod.tkp = in_err.te * $signed({1'b0, cfg.turn_kp});
  assign prod.tkd = in_err.td * $signed({1'b0, cfg.turn_kd});
  assign prod.skp = in_err.se * SIDE_KP_Q8;
  assign prod.skd = in_err.sd * SIDE_KD_Q8;

  always_comb begin
    valid_nxt = in_ready ? in_valid : valid_r;
    prod_nxt  = acc ? prod : prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

/* src/tapwm_pow_stage.sv */
`timescale 1ns / 1ps
// Third pipeline stage: per-axis product sums, floor shift by 8, saturation.
// Depends on tapwm_pkg.
module tapwm_pow_stage import tapwm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  prod_t in_prod,
  output logic  out_valid,
  input  logic  out_ready,
  output pow_t  out_pow
);

  logic               valid_r, valid_nxt;
  pow_t               pow_r, pow_nxt;
  pow_t               pow;
  logic               acc;
  logic signed [64:0] dacc;
  logic signed [28:0] tacc;
  logic signed [36:0] sacc;

  assign in_ready  = !valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_pow   = pow_r;

  assign dacc = 65'(in_prod.dkp) + 65'(in_prod.dkd) + 65'(in_prod.dki);
  assign tacc = 29'(in_prod.tkp) + 29'(in_prod.tkd);
  assign sacc = 37'(in_prod.skp) + 37'(in_prod.skd);

  // Dropping the low 8 bits of a two's complement value is a floor divide
  assign pow.drive = sat32(64'($signed(dacc[64:8])));
  assign pow.turn  = sat32(64'($signed(tacc[28:8])));
  assign pow.side  = sat32(64'($signed(sacc[36:8])));

  always_comb begin
    valid_nxt = in_ready ? in_valid : valid_r;
    pow_nxt   = acc ? pow : pow_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pow_r <= pow_nxt;
  end

endmodule

/* src/tapwm_mix_stage.sv */
`timescale 1ns / 1ps
// Last pipeline stage: holonomic wheel mix with saturation; output register.
// Depends on tapwm_pkg.
module tapwm_mix_stage import tapwm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  pow_t in_pow,
  output logic out_valid,
  input  logic out_ready,
  output pow_t out_pow,
  output spd_t out_spd
);

  logic               valid_r, valid_nxt;
  pow_t               pow_r, pow_nxt;
  spd_t               spd_r, spd_nxt;
  spd_t               spd;
  logic               acc;
  logic signed [33:0] d, s, t;

  assign in_ready  = !valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_pow   = pow_r;
  assign out_spd   = spd_r;

  assign d = 34'(in_pow.drive);
  assign s = 34'(in_pow.side);
  assign t = 34'(in_pow.turn);

  assign spd.front_right = sat32(64'(d - s - t));
  assign spd.front_left  = sat32(64'(d + s + t));
  assign spd.back_right  = sat32(64'(d + s - t));
  assign spd.back_left   = sat32(64'(d - s + t));

  always_comb begin
    valid_nxt = in_ready ? in_valid : valid_r;
    pow_nxt   = acc ? in_pow : pow_r;
    spd_nxt   = acc ? spd : spd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pow_r <= pow_nxt;
    spd_r <= spd_nxt;
  end

endmodule
